// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the converter checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/e2j_pkg.sv =====
// ----------------------------------------------------------------------------
// e2j_pkg
// types and constants shared by the EUC-JP to ISO-2022-JP converter
// ----------------------------------------------------------------------------
package e2j_pkg;

    // input item
    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } req_t;

    // result item
    typedef struct packed {
        logic [6:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       last_of_run;
    } res_t;

    // designated character set
    typedef enum logic [1:0] {
        SET_ASCII,
        SET_KANJI,
        SET_KANA,
        SET_SUPP
    } char_set_t;

    // partial character state
    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_LEAD,
        PEND_SS2,
        PEND_SS3,
        PEND_SS3_TRAIL
    } pend_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK,
        ST_ILLEGAL,
        ST_INCOMPLETE
    } status_t;

    // first shift sequence of a job
    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_SI,
        PRE_ROMAN
    } pre_t;

    // second shift sequence of a job
    typedef enum logic [1:0] {
        MID_NONE,
        MID_SO,
        MID_KANJI,
        MID_SUPP
    } mid_t;

    // classified work for the back end: shifts, up to two chars, a status
    typedef struct packed {
        pre_t       pre;
        mid_t       mid;
        logic [1:0] nch;
        logic [6:0] byte0;
        logic [6:0] byte1;
        status_t    status;
    } job_t;

    // control bytes
    localparam logic [7:0] CMASK       = 8'h80;
    localparam logic [7:0] SS2         = 8'h8E;
    localparam logic [7:0] SS3         = 8'h8F;
    localparam logic [6:0] ESC         = 7'h1B;
    localparam logic [6:0] SI          = 7'h0F;
    localparam logic [6:0] SO          = 7'h0E;
    localparam logic [6:0] G0_SB_INTRO = 7'h28;
    localparam logic [6:0] G0_MB_INTRO = 7'h24;
    localparam logic [6:0] G0_MB_EXT   = 7'h28;

    // default escape final bytes
    localparam logic [6:0] ROMAN_FINAL_RST = 7'h4A;
    localparam logic [6:0] KANJI_FINAL_RST = 7'h42;
    localparam logic [6:0] SUPP_FINAL_RST  = 7'h44;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROMAN_FINAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KANJI_FINAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUPP_FINAL  = 2'd2;

endpackage

// ===== rtl/core/eucjp_to_iso2022jp_converter_core.sv =====
// ----------------------------------------------------------------------------
// eucjp_to_iso2022jp_converter_core
// EUC-JP byte stream in, 7-bit ISO-2022-JP result stream out
// ----------------------------------------------------------------------------
// One EUC-JP byte (or a flush) is taken per cycle while req_stall is low.
// Each byte is classified in the same cycle and, if it produces results,
// queued as one job of up to seven results (shift escapes, character bytes,
// status). The output sequencer sends one result per cycle while res_stall is
// low; plain ASCII and held lead bytes keep a rate of one byte per cycle. The
// job queue holds FIFO_DEPTH jobs and req_stall rises only when it is full,
// as when escape bursts or res_stall back up the output. A job is registered
// in the queue and then in the sequencer's current-job register. The
// configuration port is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module eucjp_to_iso2022jp_converter_core
    import e2j_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [6:0]           cfg_data
);

    logic job_push;
    job_t job_in;
    logic queue_full;
    logic job_pop;
    job_t job_out;
    logic job_avail;

    assign req_stall = queue_full;

    // classifier
    e2j_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_data   (req_data),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job_data   (job_in)
    );

    // job queue
    e2j_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (queue_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .not_empty (job_avail)
    );

    // output sequencer
    e2j_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (job_avail),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

// ===== rtl/core/e2j_front.sv =====
// ----------------------------------------------------------------------------
// e2j_front
// accepts EUC-JP bytes, tracks set and partial character, emits jobs
// ----------------------------------------------------------------------------
module e2j_front
    import e2j_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  req_t req_data,
    input  logic queue_full,
    output logic job_push,
    output job_t job_data
);

    char_set_t  set_reg, set_next;
    pend_t      pend_reg, pend_next;
    logic [7:0] held_reg, held_next;
    logic       accept;
    logic       job_used;
    logic       b_kanji;
    logic       b_kana;
    logic [7:0] b;
    job_t       job;

    assign accept  = req_valid && !queue_full;
    assign b       = req_data.in_byte;
    assign b_kanji = (b >= 8'hA1) && (b <= 8'hFE);
    assign b_kana  = (b >= 8'hA1) && (b <= 8'hDF);

    // classify the byte against the pending state
    always_comb
    begin
        set_next  = set_reg;
        pend_next = pend_reg;
        held_next = held_reg;
        job.pre    = PRE_NONE;
        job.mid    = MID_NONE;
        job.nch    = 2'd0;
        job.byte0  = 7'd0;
        job.byte1  = 7'd0;
        job.status = ST_OK;

        if (req_data.req_type)
        begin
            // flush back to ascii
            if (set_reg == SET_KANJI || set_reg == SET_SUPP)
            begin
                job.pre = PRE_ROMAN;
            end
            else if (set_reg == SET_KANA)
            begin
                job.pre = PRE_SI;
            end
            if (pend_reg != PEND_NONE)
            begin
                job.status = ST_INCOMPLETE;
            end
            set_next  = SET_ASCII;
            pend_next = PEND_NONE;
            held_next = 8'd0;
        end
        else
        begin
            unique case (pend_reg)
                PEND_NONE:
                begin
                    if ((b & CMASK) == 8'd0)
                    begin
                        if (set_reg == SET_KANJI || set_reg == SET_SUPP)
                        begin
                            job.pre = PRE_ROMAN;
                        end
                        else if (set_reg == SET_KANA)
                        begin
                            job.pre = PRE_SI;
                        end
                        job.nch   = 2'd1;
                        job.byte0 = b[6:0];
                        set_next  = SET_ASCII;
                    end
                    else if (b_kanji)
                    begin
                        held_next = b;
                        pend_next = PEND_LEAD;
                    end
                    else if (b == SS2)
                    begin
                        pend_next = PEND_SS2;
                    end
                    else if (b == SS3)
                    begin
                        pend_next = PEND_SS3;
                    end
                    else
                    begin
                        job.status = ST_ILLEGAL;
                        held_next  = 8'd0;
                    end
                end
                PEND_LEAD:
                begin
                    pend_next = PEND_NONE;
                    held_next = 8'd0;
                    if (!b_kanji)
                    begin
                        job.status = ST_ILLEGAL;
                    end
                    else
                    begin
                        if (set_reg == SET_KANA)
                        begin
                            job.pre = PRE_SI;
                        end
                        if (set_reg != SET_KANJI)
                        begin
                            job.mid = MID_KANJI;
                        end
                        job.nch   = 2'd2;
                        job.byte0 = held_reg[6:0];
                        job.byte1 = b[6:0];
                        set_next  = SET_KANJI;
                    end
                end
                PEND_SS2:
                begin
                    pend_next = PEND_NONE;
                    if (!b_kana)
                    begin
                        job.status = ST_ILLEGAL;
                        held_next  = 8'd0;
                    end
                    else
                    begin
                        if (set_reg == SET_KANJI || set_reg == SET_SUPP)
                        begin
                            job.pre = PRE_ROMAN;
                        end
                        if (set_reg != SET_KANA)
                        begin
                            job.mid = MID_SO;
                        end
                        job.nch   = 2'd1;
                        job.byte0 = b[6:0];
                        set_next  = SET_KANA;
                    end
                end
                PEND_SS3:
                begin
                    if (!b_kanji)
                    begin
                        job.status = ST_ILLEGAL;
                        pend_next  = PEND_NONE;
                        held_next  = 8'd0;
                    end
                    else
                    begin
                        held_next = b;
                        pend_next = PEND_SS3_TRAIL;
                    end
                end
                PEND_SS3_TRAIL:
                begin
                    pend_next = PEND_NONE;
                    held_next = 8'd0;
                    if (!b_kanji)
                    begin
                        job.status = ST_ILLEGAL;
                    end
                    else
                    begin
                        if (set_reg == SET_KANA)
                        begin
                            job.pre = PRE_SI;
                        end
                        if (set_reg != SET_SUPP)
                        begin
                            job.mid = MID_SUPP;
                        end
                        job.nch   = 2'd2;
                        job.byte0 = held_reg[6:0];
                        job.byte1 = b[6:0];
                        set_next  = SET_SUPP;
                    end
                end
                default:
                begin
                    job.status = ST_ILLEGAL;
                    pend_next  = PEND_NONE;
                    held_next  = 8'd0;
                end
            endcase
        end
    end

    // only jobs that produce results enter the queue
    assign job_used = (job.pre != PRE_NONE) || (job.mid != MID_NONE) ||
                      (job.nch != 2'd0) || (job.status != ST_OK);
    assign job_push = accept && job_used;
    assign job_data = job;

    // state update on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg  <= SET_ASCII;
            pend_reg <= PEND_NONE;
            held_reg <= 8'd0;
        end
        else if (accept)
        begin
            set_reg  <= set_next;
            pend_reg <= pend_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/core/e2j_fifo.sv =====
// ----------------------------------------------------------------------------
// e2j_fifo
// small job queue between the classifier and the output sequencer
// ----------------------------------------------------------------------------
module e2j_fifo
    import e2j_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/e2j_back.sv =====
// ----------------------------------------------------------------------------
// e2j_back
// expands one job per run into escape, character and status results
// ----------------------------------------------------------------------------
module e2j_back
    import e2j_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_avail,
    input  job_t                 job_data,
    output logic                 job_pop,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [6:0]           cfg_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res_data
);

    logic [6:0] roman_reg;
    logic [6:0] kanji_reg;
    logic [6:0] supp_reg;
    job_t       cur_reg, cur_next;
    logic       busy_reg, busy_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] len_a, len_b, total, rb, rc;
    logic       last;
    logic       xfer;
    logic       load;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roman_reg <= ROMAN_FINAL_RST;
            kanji_reg <= KANJI_FINAL_RST;
            supp_reg  <= SUPP_FINAL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROMAN_FINAL: roman_reg <= cfg_data;
                REG_KANJI_FINAL: kanji_reg <= cfg_data;
                REG_SUPP_FINAL:  supp_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // run length pieces of the current job
    always_comb
    begin
        unique case (cur_reg.pre)
            PRE_SI:    len_a = 3'd1;
            PRE_ROMAN: len_a = 3'd3;
            default:   len_a = 3'd0;
        endcase
        unique case (cur_reg.mid)
            MID_SO:    len_b = 3'd1;
            MID_KANJI: len_b = 3'd3;
            MID_SUPP:  len_b = 3'd4;
            default:   len_b = 3'd0;
        endcase
        total = len_a + len_b + {1'b0, cur_reg.nch} + {2'b0, cur_reg.status != ST_OK};
        rb    = idx_reg - len_a;
        rc    = rb - len_b;
        last  = (idx_reg == total - 3'd1);
    end

    // result item at the current position of the run
    always_comb
    begin
        res_data.out_byte    = 7'd0;
        res_data.byte_valid  = 1'b1;
        res_data.status      = ST_OK;
        res_data.last_of_run = last;
        if (idx_reg < len_a)
        begin
            if (cur_reg.pre == PRE_SI)
            begin
                res_data.out_byte = SI;
            end
            else
            begin
                case (idx_reg[1:0])
                    2'd0:    res_data.out_byte = ESC;
                    2'd1:    res_data.out_byte = G0_SB_INTRO;
                    default: res_data.out_byte = roman_reg;
                endcase
            end
        end
        else if (rb < len_b)
        begin
            if (cur_reg.mid == MID_SO)
            begin
                res_data.out_byte = SO;
            end
            else if (cur_reg.mid == MID_KANJI)
            begin
                case (rb[1:0])
                    2'd0:    res_data.out_byte = ESC;
                    2'd1:    res_data.out_byte = G0_MB_INTRO;
                    default: res_data.out_byte = kanji_reg;
                endcase
            end
            else
            begin
                case (rb[1:0])
                    2'd0:    res_data.out_byte = ESC;
                    2'd1:    res_data.out_byte = G0_MB_INTRO;
                    2'd2:    res_data.out_byte = G0_MB_EXT;
                    default: res_data.out_byte = supp_reg;
                endcase
            end
        end
        else if (rc < {1'b0, cur_reg.nch})
        begin
            res_data.out_byte = (rc == 3'd0) ? cur_reg.byte0 : cur_reg.byte1;
        end
        else
        begin
            res_data.byte_valid = 1'b0;
            res_data.status     = cur_reg.status;
        end
    end

    // run sequencing: take the next job as the last item transfers
    assign res_valid = busy_reg;
    assign xfer      = busy_reg && !res_stall;
    assign load      = !busy_reg || (xfer && last);
    assign job_pop   = load && job_avail;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        cur_next  = cur_reg;
        if (load)
        begin
            busy_next = job_avail;
            idx_next  = 3'd0;
            if (job_avail)
            begin
                cur_next = job_data;
            end
        end
        else if (xfer)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

// ===== rtl/core/e2j_checker.sv =====
// ----------------------------------------------------------------------------
// e2j_checker
// port-level checks on the converter result stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module e2j_checker
    import e2j_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_stall,
    input res_t res_data
);

    logic res_hold;
    logic res_flag;
    logic flag_alone;
    logic res_blank;
    logic has_flag;

    assign res_hold   = res_valid && res_stall;
    assign has_flag   = (res_data.status != ST_OK);
    assign res_flag   = res_valid && has_flag;
    assign flag_alone = res_data.last_of_run && !res_data.byte_valid &&
                        (res_data.out_byte == 7'd0);
    assign res_blank  = res_valid && !res_data.byte_valid;

    // a stalled result holds
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_hold, res_valid && $stable(res_data), "not held")

    // an error or incomplete report ends its run and carries no byte
    `ASSERT_IMPLIES(a_status_last, clk, rst_n, res_flag, flag_alone, "status not alone at run end")

    // a result without a byte always reports a status
    `ASSERT_IMPLIES(a_empty_status, clk, rst_n, res_blank, has_flag, "byteless result is ok")

endmodule

bind eucjp_to_iso2022jp_converter_core e2j_checker u_e2j_checker (.*);
